// ----- rtl/twcs_pkg.sv -----
`default_nettype none

package twcs_pkg;

    // Screen size defaults
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;

    // Field widths
    localparam int COL_W     = 10;
    localparam int HGT_W     = 16;
    localparam int SIDE_W    = 2;
    localparam int FRAC_W    = 16;
    localparam int SIGN_W    = 2;
    localparam int TEX_W     = 11;
    localparam int ROW_W     = 10;
    localparam int TEXEL_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_TEX   = 4;

    // Row offset m = 2*row + h - H, its magnitude and the divider widths
    localparam int MAG_W  = HGT_W + 1;
    localparam int M_W    = HGT_W + 2;
    localparam int PROD_W = MAG_W + TEX_W;
    localparam int QUO_W  = 11;
    localparam int CNT_W  = 4;

    localparam logic [TEX_W-1:0] TEX_RESET = 11'd64;
    localparam int TEXEL_MAX_INT = (1 << TEXEL_W) - 1;

    // Item action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_W0,
        CFG_TEX_W1,
        CFG_TEX_W2,
        CFG_TEX_W3,
        CFG_TEX_H0,
        CFG_TEX_H1,
        CFG_TEX_H2,
        CFG_TEX_H3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic step_start;
        logic mul;
        logic div_step;
        logic emit;
    } twcs_cmd_t;

    typedef struct packed {
        logic item_valid;
        logic item_step;
        logic span_active;
        logic div_last;
        logic out_free;
    } twcs_status_t;

endpackage

`default_nettype wire

// ----- rtl/twcs_ifs.sv -----
`default_nettype none

// Input item channel
interface twcs_item_if;
    import twcs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [COL_W-1:0]         column;
    logic [HGT_W-1:0]         slice_height;
    logic [SIDE_W-1:0]        texture_side;
    logic [FRAC_W-1:0]        wall_frac;
    logic signed [SIGN_W-1:0] ray_y_sign;

    modport source (output valid, action, column, slice_height, texture_side,
                    wall_frac, ray_y_sign, input ready);
    modport sink   (input valid, action, column, slice_height, texture_side,
                    wall_frac, ray_y_sign, output ready);
endinterface

// Pixel result channel
interface twcs_pixel_if;
    import twcs_pkg::*;
    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   screen_x;
    logic [ROW_W-1:0]   screen_y;
    logic [TEXEL_W-1:0] texel_x;
    logic [TEXEL_W-1:0] texel_y;
    logic [SIDE_W-1:0]  texture_pick;
    logic               in_window;
    logic               last_row;

    modport source (output valid, screen_x, screen_y, texel_x, texel_y,
                    texture_pick, in_window, last_row, input ready);
    modport sink   (input valid, screen_x, screen_y, texel_x, texel_y,
                    texture_pick, in_window, last_row, output ready);
endinterface

// Configuration write channel
interface twcs_cfg_if;
    import twcs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TEX_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/twcs_ctrl.sv -----
`default_nettype none

module twcs_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire twcs_pkg::twcs_status_t status,
    output twcs_pkg::twcs_cmd_t         cmd
);
    import twcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = 1'b1;
                if (status.item_valid)
                begin
                    if (!status.item_step)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (status.span_active)
                    begin
                        cmd.step_start = 1'b1;
                        state_next     = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A started step always goes through the multiply next
    a_step_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_start |=> (state_reg == ST_MUL))
        else $error("step start not followed by multiply");

    // The final quotient bit leads to the emit state
    a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.div_last) |=> (state_reg == ST_EMIT))
        else $error("divider end not followed by emit");

    // Never overwrite a pixel the sink has not taken
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("emit while output register busy");

endmodule

`default_nettype wire

// ----- rtl/twcs_dp.sv -----
`default_nettype none

module twcs_dp #(
    parameter int SCREEN_WIDTH  = twcs_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = twcs_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    twcs_item_if.sink                  item,
    twcs_pixel_if.source               pixel,
    twcs_cfg_if.sink                   cfg,
    input  wire twcs_pkg::twcs_cmd_t   cmd,
    output twcs_pkg::twcs_status_t     status
);
    import twcs_pkg::*;

    localparam int HALF = SCREEN_HEIGHT / 2;
    localparam logic [ROW_W-1:0] HALF_ROW  = ROW_W'(HALF);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [COL_W:0]   WIDTH_CMP = (COL_W + 1)'(SCREEN_WIDTH);

    // Texture size registers
    logic [TEX_W-1:0] tex_w_reg [NUM_TEX];
    logic [TEX_W-1:0] tex_h_reg [NUM_TEX];

    // Span state
    logic [COL_W-1:0]   held_column_reg;
    logic [HGT_W-1:0]   held_height_reg;
    logic [SIDE_W-1:0]  held_side_reg;
    logic [TEXEL_W-1:0] held_texel_col_reg;
    logic [ROW_W-1:0]   current_row_reg;
    logic [ROW_W-1:0]   span_end_reg;
    logic               span_active_reg;

    // Per-pixel working registers
    logic [ROW_W-1:0]   w_row_reg;
    logic               w_last_reg;
    logic               w_neg_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [PROD_W-1:0]  rem_reg;
    logic [PROD_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // Output register
    logic               out_valid_reg;
    logic [COL_W-1:0]   out_x_reg;
    logic [ROW_W-1:0]   out_y_reg;
    logic [TEXEL_W-1:0] out_tx_reg;
    logic [TEXEL_W-1:0] out_ty_reg;
    logic [SIDE_W-1:0]  out_pick_reg;
    logic               out_win_reg;
    logic               out_last_reg;

    // Load-side signals
    logic [HGT_W-2:0]        half_h;
    logic [ROW_W-1:0]        start_row;
    logic [MAG_W-1:0]        end_sum;
    logic [ROW_W-1:0]        end_row;
    logic [TEX_W-1:0]        sel_w;
    logic [FRAC_W+TEX_W-1:0] frac_prod;
    logic [TEX_W-1:0]        tx;
    logic signed [TEX_W+1:0] tx_mir;
    logic                    mirror;
    logic [TEXEL_W-1:0]      texel_col;

    // Step-side signals
    logic [MAG_W-1:0]        row_sum;
    logic signed [M_W-1:0]   m_s;
    logic [ROW_W:0]          next_row;
    logic                    is_last;
    logic                    quo_bit;
    logic [TEXEL_W-1:0]      texel_row;

    assign item.ready = cmd.accept;
    assign cfg.ready  = 1'b1;

    assign status.item_valid  = item.valid;
    assign status.item_step   = (item.action == ACT_STEP);
    assign status.span_active = span_active_reg;
    assign status.div_last    = (cnt_reg == '0);
    assign status.out_free    = !out_valid_reg || pixel.ready;

    // Write texture sizes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TEX; i++)
            begin
                tex_w_reg[i] <= TEX_RESET;
                tex_h_reg[i] <= TEX_RESET;
            end
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_TEX_W0: tex_w_reg[0] <= cfg.data;
                CFG_TEX_W1: tex_w_reg[1] <= cfg.data;
                CFG_TEX_W2: tex_w_reg[2] <= cfg.data;
                CFG_TEX_W3: tex_w_reg[3] <= cfg.data;
                CFG_TEX_H0: tex_h_reg[0] <= cfg.data;
                CFG_TEX_H1: tex_h_reg[1] <= cfg.data;
                CFG_TEX_H2: tex_h_reg[2] <= cfg.data;
                CFG_TEX_H3: tex_h_reg[3] <= cfg.data;
                default:    tex_w_reg[0] <= tex_w_reg[0];
            endcase
        end
    end

    // Compute row span and texel column of a new slice
    always_comb
    begin
        half_h = item.slice_height[HGT_W-1:1];
        if (HGT_W'(half_h) >= HGT_W'(HALF))
        begin
            start_row = '0;
        end
        else
        begin
            start_row = HALF_ROW - ROW_W'(half_h);
        end
        end_sum = MAG_W'(half_h) + MAG_W'(HALF);
        if (end_sum >= MAG_W'(SCREEN_HEIGHT))
        begin
            end_row = LAST_ROW;
        end
        else
        begin
            end_row = ROW_W'(end_sum);
        end

        sel_w     = tex_w_reg[item.texture_side];
        frac_prod = (FRAC_W + TEX_W)'(item.wall_frac) * (FRAC_W + TEX_W)'(sel_w);
        tx        = frac_prod[FRAC_W+TEX_W-1:FRAC_W];
        tx_mir    = $signed((TEX_W + 2)'(sel_w)) - $signed((TEX_W + 2)'(tx))
                    - $signed((TEX_W + 2)'(1));
        mirror    = (item.texture_side == 2'd0 && item.ray_y_sign == 2'sd1)
                    || (item.texture_side == 2'd1 && item.ray_y_sign[SIGN_W-1]);
        if (mirror)
        begin
            if (tx_mir < 0)
            begin
                texel_col = '0;
            end
            else if (tx_mir > $signed((TEX_W + 2)'(TEXEL_MAX_INT)))
            begin
                texel_col = TEXEL_W'(TEXEL_MAX_INT);
            end
            else
            begin
                texel_col = tx_mir[TEXEL_W-1:0];
            end
        end
        else if (tx > TEX_W'(TEXEL_MAX_INT))
        begin
            texel_col = TEXEL_W'(TEXEL_MAX_INT);
        end
        else
        begin
            texel_col = tx[TEXEL_W-1:0];
        end
    end

    // Form row offset, row advance and divider step
    always_comb
    begin
        row_sum   = MAG_W'({current_row_reg, 1'b0}) + MAG_W'(held_height_reg);
        m_s       = $signed({1'b0, row_sum}) - $signed(M_W'(SCREEN_HEIGHT));
        next_row  = (ROW_W + 1)'(current_row_reg) + (ROW_W + 1)'(1);
        is_last   = (next_row >= (ROW_W + 1)'(span_end_reg));
        quo_bit   = (rem_reg >= dsh_reg);
        if (w_neg_reg)
        begin
            texel_row = '0;
        end
        else if (quo_reg > QUO_W'(TEXEL_MAX_INT))
        begin
            texel_row = TEXEL_W'(TEXEL_MAX_INT);
        end
        else
        begin
            texel_row = quo_reg[TEXEL_W-1:0];
        end
    end

    // Update span state on load and step transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_column_reg    <= '0;
            held_height_reg    <= '0;
            held_side_reg      <= '0;
            held_texel_col_reg <= '0;
            current_row_reg    <= '0;
            span_end_reg       <= '0;
            span_active_reg    <= 1'b0;
        end
        else if (cmd.load)
        begin
            held_column_reg    <= item.column;
            held_height_reg    <= item.slice_height;
            held_side_reg      <= item.texture_side;
            held_texel_col_reg <= texel_col;
            current_row_reg    <= start_row;
            span_end_reg       <= end_row;
            span_active_reg    <= (start_row < end_row);
        end
        else if (cmd.step_start)
        begin
            current_row_reg <= next_row[ROW_W-1:0];
            span_active_reg <= !is_last;
        end
    end

    // Capture row operands, multiply, then divide one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.step_start)
        begin
            w_row_reg  <= current_row_reg;
            w_last_reg <= is_last;
            w_neg_reg  <= m_s[M_W-1];
            mag_reg    <= m_s[M_W-1] ? '0 : MAG_W'(m_s);
            dsh_reg    <= PROD_W'({held_height_reg, 1'b0}) << (QUO_W - 1);
        end
        else if (cmd.mul)
        begin
            rem_reg <= PROD_W'(mag_reg) * PROD_W'(tex_h_reg[held_side_reg]);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (quo_bit)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], quo_bit};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Count quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.mul)
        begin
            cnt_reg <= CNT_W'(QUO_W - 1);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Hold the pixel until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_x_reg    <= held_column_reg;
            out_y_reg    <= w_row_reg;
            out_tx_reg   <= held_texel_col_reg;
            out_ty_reg   <= texel_row;
            out_pick_reg <= held_side_reg;
            out_win_reg  <= ({1'b0, held_column_reg} < WIDTH_CMP);
            out_last_reg <= w_last_reg;
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.screen_x     = out_x_reg;
    assign pixel.screen_y     = out_y_reg;
    assign pixel.texel_x      = out_tx_reg;
    assign pixel.texel_y      = out_ty_reg;
    assign pixel.texture_pick = out_pick_reg;
    assign pixel.in_window    = out_win_reg;
    assign pixel.last_row     = out_last_reg;

    // An active span always has rows left
    a_span_rows: assert property (@(posedge clk) disable iff (!rst_n)
        span_active_reg |-> (current_row_reg < span_end_reg))
        else $error("active span with no rows left");

    // Partial remainder stays below twice the shifted divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> ((PROD_W + 1)'(rem_reg) < {dsh_reg, 1'b0}))
        else $error("divider remainder out of range");

    // An emitted pixel is presented on the next cycle
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted pixel not presented");

endmodule

`default_nettype wire

// ----- rtl/textured_wall_column_span_unit.sv -----
`default_nettype none

// Textured wall column span unit. A load transaction (action 0) latches a wall
// slice: screen column, texel column from the hit fraction and texture width
// (mirrored for side 0 with positive ray y sign or side 1 with negative sign),
// and the row span of half the slice height either side of mid-screen, clamped
// to the screen. Each step transaction (action 1) emits one pixel of that span,
// top to bottom, with last_row set on the final one; a step with no span left
// emits nothing. Loads and empty steps leave the unit idle. For a pixel step,
// the accepting edge captures the row offset; then the unit runs the
// offset-times-texture-height multiply, the radix-2 restoring divider by twice
// the slice height (one quotient bit per cycle) and the load of the output
// register, which waits while the sink has not taken the previous pixel. No
// new transaction is accepted until the pixel sits in the output register;
// the next is accepted then, even while the sink has not taken it. Texture
// sizes are to be written through the configuration channel while the unit is
// idle; the unit does not enforce it. A step uses the held texture's height.
module textured_wall_column_span_unit #(
    parameter int SCREEN_WIDTH  = twcs_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = twcs_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    twcs_item_if.sink    item,
    twcs_pixel_if.source pixel,
    twcs_cfg_if.sink     cfg
);
    import twcs_pkg::*;

    twcs_cmd_t    cmd;
    twcs_status_t status;

    twcs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    twcs_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .pixel  (pixel),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
module tb;
    import twcs_pkg::*;

    localparam int SCREEN_W     = SCREEN_WIDTH_DEF;
    localparam int SCREEN_H     = SCREEN_HEIGHT_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 4;
    localparam int DIR_ROWS     = 27;

    typedef struct packed {
        logic                     action;
        logic [COL_W-1:0]         column;
        logic [HGT_W-1:0]         slice_height;
        logic [SIDE_W-1:0]        texture_side;
        logic [FRAC_W-1:0]        wall_frac;
        logic signed [SIGN_W-1:0] ray_y_sign;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0]   screen_x;
        logic [ROW_W-1:0]   screen_y;
        logic [TEXEL_W-1:0] texel_x;
        logic [TEXEL_W-1:0] texel_y;
        logic [SIDE_W-1:0]  texture_pick;
        logic               in_window;
        logic               last_row;
    } pixel_t;

    typedef enum {NO_PIXEL, GIVEN_PIXEL, MODEL_PIXEL} row_check_t;

    typedef struct {
        row_check_t check;
        logic       act;
        int         col;
        int         hgt;
        int         side;
        int         frac;
        int         sgn;
        int         sx;
        int         sy;
        int         tx;
        int         ty;
        int         pick;
        int         win;
        int         last;
    } dir_row_t;

    // Directed rows: fields of the item, then the pixel where it is typed in
    dir_row_t dir_rows [DIR_ROWS] = '{
        // step before any load
        '{NO_PIXEL,    ACT_STEP, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0, 0, 0},
        // two-row span at mid-screen
        '{NO_PIXEL,    ACT_LOAD, 5, 2, 2, 0, 0,         0, 0, 0, 0, 0, 0, 0},
        '{GIVEN_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         5, 383, 0, 0, 2, 1, 0},
        '{GIVEN_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         5, 384, 0, 32, 2, 1, 1},
        // step past the end of the span, other fields at their extremes
        '{NO_PIXEL,    ACT_STEP, 1023, 65535, 3, 65535, -1, 0, 0, 0, 0, 0, 0, 0},
        // zero height, then height one: both give an empty span
        '{NO_PIXEL,    ACT_LOAD, 1023, 0, 3, 65535, -1, 0, 0, 0, 0, 0, 0, 0},
        '{NO_PIXEL,    ACT_STEP, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0, 0, 0},
        '{NO_PIXEL,    ACT_LOAD, 1023, 1, 0, 65535, 1,  0, 0, 0, 0, 0, 0, 0},
        '{NO_PIXEL,    ACT_STEP, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0, 0, 0},
        // mirrored texel column: side 0 with positive sign
        '{NO_PIXEL,    ACT_LOAD, 1023, 2, 0, 0, 1,      0, 0, 0, 0, 0, 0, 0},
        '{GIVEN_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         1023, 383, 63, 0, 0, 1, 0},
        // reload mid-span, side 1 with sign -2
        '{NO_PIXEL,    ACT_LOAD, 0, 2, 1, 0, -2,        0, 0, 0, 0, 0, 0, 0},
        '{GIVEN_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         0, 383, 63, 0, 1, 1, 0},
        '{NO_PIXEL,    ACT_LOAD, 0, 2, 1, 65535, -1,    0, 0, 0, 0, 0, 0, 0},
        '{GIVEN_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         0, 383, 0, 0, 1, 1, 0},
        // maximum height clamps the span to the screen
        '{MODEL_PIXEL, ACT_LOAD, 517, 65535, 3, 65535, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODEL_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0, 0, 0},
        '{MODEL_PIXEL, ACT_STEP, 1023, 65535, 3, 65535, -2, 0, 0, 0, 0, 0, 0, 0},
        // side 1 with positive sign is not mirrored
        '{MODEL_PIXEL, ACT_LOAD, 300, 100, 1, 32768, 1, 0, 0, 0, 0, 0, 0, 0},
        '{MODEL_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0, 0, 0},
        '{MODEL_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0, 0, 0},
        '{MODEL_PIXEL, ACT_LOAD, 700, 767, 2, 4660, -1, 0, 0, 0, 0, 0, 0, 0},
        '{MODEL_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0, 0, 0},
        // odd height, run to the end and one step beyond
        '{MODEL_PIXEL, ACT_LOAD, 77, 3, 0, 65535, 0,    0, 0, 0, 0, 0, 0, 0},
        '{MODEL_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0, 0, 0},
        '{MODEL_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0, 0, 0},
        '{MODEL_PIXEL, ACT_STEP, 0, 0, 0, 0, 0,         0, 0, 0, 0, 0, 0, 0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    twcs_item_if  item_ch ();
    twcs_pixel_if pixel_ch ();
    twcs_cfg_if   cfg_ch ();

    textured_wall_column_span_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .pixel (pixel_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state: texture sizes and the loaded span
    logic [TEX_W-1:0]   tex_width [NUM_TEX];
    logic [TEX_W-1:0]   tex_height [NUM_TEX];
    logic [COL_W-1:0]   span_col;
    logic [HGT_W-1:0]   span_height;
    logic [SIDE_W-1:0]  span_side;
    logic [TEXEL_W-1:0] span_texel_x;
    logic [ROW_W-1:0]   span_row;
    logic [ROW_W-1:0]   span_stop;
    logic               span_live;

    pixel_t pending_pixels [$];
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    bit     quiet          = 1'b0;
    bit     hold_request   = 1'b0;

    always #2 clk = ~clk;

    function automatic logic [TEXEL_W-1:0] clamp_texel(input longint v);
        if (v < 0)
            return '0;
        if (v > TEXEL_MAX_INT)
            return TEXEL_W'(TEXEL_MAX_INT);
        return v[TEXEL_W-1:0];
    endfunction

    // Apply one item to the span state; return 1 with the pixel if one is due
    function automatic bit predict_wall_pixel(input item_t it, output pixel_t px);
        longint hgt;
        longint wid;
        longint tx;
        longint top;
        longint bot;
        longint d;
        longint th;
        longint ty;
        int     sgn;
        int     nxt;
        px = '0;
        if (it.action == ACT_LOAD)
        begin
            hgt = longint'(it.slice_height);
            wid = longint'(tex_width[it.texture_side]);
            sgn = $signed(it.ray_y_sign);
            tx  = (longint'(it.wall_frac) * wid) >> 16;
            if ((it.texture_side == 2'd0 && sgn > 0) || (it.texture_side == 2'd1 && sgn < 0))
                tx = wid - tx - 1;
            top = SCREEN_H / 2 - hgt / 2;
            if (top < 0)
                top = 0;
            bot = hgt / 2 + SCREEN_H / 2;
            if (bot >= SCREEN_H)
                bot = SCREEN_H - 1;
            span_col     = it.column;
            span_height  = it.slice_height;
            span_side    = it.texture_side;
            span_texel_x = clamp_texel(tx);
            span_row     = top[ROW_W-1:0];
            span_stop    = bot[ROW_W-1:0];
            span_live    = (top < bot);
            return 1'b0;
        end
        if (!span_live)
            return 1'b0;
        // Texel row from the offset below the slice top, scaled by 256
        hgt = longint'(span_height);
        th  = longint'(tex_height[span_side]);
        d   = longint'(span_row) * 256 - longint'(SCREEN_H) * 128 + hgt * 128;
        ty  = 0;
        if (hgt != 0)
            ty = ((d * th) / hgt) / 256;
        nxt = int'(span_row) + 1;
        px.screen_x     = span_col;
        px.screen_y     = span_row;
        px.texel_x      = span_texel_x;
        px.texel_y      = clamp_texel(ty);
        px.texture_pick = span_side;
        px.in_window    = (int'(span_col) < SCREEN_W);
        px.last_row     = (nxt >= int'(span_stop));
        if (nxt >= int'(span_stop))
            span_live = 1'b0;
        span_row = nxt[ROW_W-1:0];
        return 1'b1;
    endfunction

    function automatic item_t random_step();
        logic [63:0] bits;
        item_t       it;
        bits      = {$urandom, $urandom};
        it        = bits[$bits(item_t)-1:0];
        it.action = ACT_STEP;
        return it;
    endfunction

    // Offer one item after a random gap and wait for the transaction
    task automatic send_item(input item_t it, output bit emitted, output pixel_t px);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= it.action;
        item_ch.column       <= it.column;
        item_ch.slice_height <= it.slice_height;
        item_ch.texture_side <= it.texture_side;
        item_ch.wall_frac    <= it.wall_frac;
        item_ch.ray_y_sign   <= it.ray_y_sign;
        do @(posedge clk); while (!item_ch.ready);
        emitted = predict_wall_pixel(it, px);
    endtask

    task automatic write_texture_reg(input cfg_idx_t idx, input logic [TEX_W-1:0] val);
        int gap;
        gap = $urandom_range(0, 15);
        if (gap > 0)
        begin
            cfg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx < CFG_TEX_H0)
            tex_width[idx[SIDE_W-1:0]] = val;
        else
            tex_height[idx[SIDE_W-1:0]] = val;
    endtask

    // Wait for every pending pixel, then let a pending step settle
    task automatic drain_pixels();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Compare each pixel transaction with the oldest pending pixel
    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel transaction with none pending: x=%0d y=%0d",
                       pixel_ch.screen_x, pixel_ch.screen_y);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("screen_x", want.screen_x, pixel_ch.screen_x);
                check_field("screen_y", want.screen_y, pixel_ch.screen_y);
                check_field("texel_x", want.texel_x, pixel_ch.texel_x);
                check_field("texel_y", want.texel_y, pixel_ch.texel_y);
                check_field("texture_pick", want.texture_pick, pixel_ch.texture_pick);
                check_field("in_window", want.in_window, pixel_ch.in_window);
                check_field("last_row", want.last_row, pixel_ch.last_row);
            end
        end
    end

    // Pixel sink: stall at random, hold off for a long stretch on request
    initial
    begin : pixel_sink
        int stall;
        pixel_ch.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                pixel_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pixel_ch.ready <= 1'b1;
            do @(posedge clk); while (!pixel_ch.valid);
        end
    end

    initial
    begin : stimulus
        item_t           it;
        pixel_t          px;
        bit              emitted;
        int              emitted_count;
        int              sel;
        int              hgt;
        int              rows;
        int              top;
        int              bot;
        int              steps;
        logic [TEX_W-1:0] wval;
        logic [TEX_W-1:0] hval;

        item_ch.valid        <= 1'b0;
        item_ch.action       <= ACT_LOAD;
        item_ch.column       <= '0;
        item_ch.slice_height <= '0;
        item_ch.texture_side <= '0;
        item_ch.wall_frac    <= '0;
        item_ch.ray_y_sign   <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_TEX_W0;
        cfg_ch.data          <= '0;

        // Reset values of the predictor
        for (int k = 0; k < NUM_TEX; k++)
        begin
            tex_width[k]  = TEX_RESET;
            tex_height[k] = TEX_RESET;
        end
        span_col     = '0;
        span_height  = '0;
        span_side    = '0;
        span_texel_x = '0;
        span_row     = '0;
        span_stop    = '0;
        span_live    = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows
        foreach (dir_rows[i])
        begin
            it.action       = dir_rows[i].act;
            it.column       = dir_rows[i].col[COL_W-1:0];
            it.slice_height = dir_rows[i].hgt[HGT_W-1:0];
            it.texture_side = dir_rows[i].side[SIDE_W-1:0];
            it.wall_frac    = dir_rows[i].frac[FRAC_W-1:0];
            it.ray_y_sign   = dir_rows[i].sgn[SIGN_W-1:0];
            send_item(it, emitted, px);
            if (dir_rows[i].check == GIVEN_PIXEL)
            begin
                px.screen_x     = dir_rows[i].sx[COL_W-1:0];
                px.screen_y     = dir_rows[i].sy[ROW_W-1:0];
                px.texel_x      = dir_rows[i].tx[TEXEL_W-1:0];
                px.texel_y      = dir_rows[i].ty[TEXEL_W-1:0];
                px.texture_pick = dir_rows[i].pick[SIDE_W-1:0];
                px.in_window    = dir_rows[i].win[0];
                px.last_row     = dir_rows[i].last[0];
                pending_pixels.push_back(px);
            end
            else if (dir_rows[i].check == MODEL_PIXEL && emitted)
                pending_pixels.push_back(px);
        end
        item_ch.valid <= 1'b0;
        drain_pixels();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // Program texture sizes: extremes first, then random
            for (int k = 0; k < NUM_TEX; k++)
            begin
                case (ph)
                    0:
                    begin
                        wval = 11'd1;
                        hval = 11'd1024;
                    end
                    1:
                    begin
                        wval = 11'd1024;
                        hval = 11'd1;
                    end
                    2:
                    begin
                        wval = k[0] ? 11'h7FF : 11'd0;
                        hval = k[1] ? 11'd0 : 11'h7FF;
                    end
                    default:
                    begin
                        wval = TEX_W'($urandom_range(1, 1024));
                        hval = TEX_W'($urandom_range(1, 1024));
                    end
                endcase
                write_texture_reg(cfg_idx_t'(CFG_TEX_W0 + k), wval);
                write_texture_reg(cfg_idx_t'(CFG_TEX_H0 + k), hval);
            end
            cfg_ch.valid <= 1'b0;
            @(posedge clk);

            // Hold off the sink while steps arrive back to back
            if (ph == NUM_PHASES - 1)
            begin
                hold_request = 1'b1;
                quiet        = 1'b1;
                it = random_step();
                it.action       = ACT_LOAD;
                it.slice_height = 16'd120;
                send_item(it, emitted, px);
                repeat (60)
                begin
                    send_item(random_step(), emitted, px);
                    if (emitted)
                        pending_pixels.push_back(px);
                end
                quiet = 1'b0;
            end

            // Random load then a run of steps, mostly to the end of the span
            emitted_count = 0;
            while (emitted_count < PHASE_ITEMS)
            begin
                quiet = ($urandom_range(0, 7) == 0);
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    hgt = $urandom_range(0, 1);
                else if (sel < 12)
                    hgt = $urandom_range(2, 48);
                else if (sel < 16)
                    hgt = $urandom_range(49, 1600);
                else if (sel < 19)
                    hgt = $urandom_range(1601, 65535);
                else
                    hgt = 65535;
                it.action       = ACT_LOAD;
                it.column       = COL_W'($urandom_range(0, 1023));
                it.slice_height = hgt[HGT_W-1:0];
                it.texture_side = SIDE_W'($urandom_range(0, 3));
                it.wall_frac    = FRAC_W'($urandom_range(0, 65535));
                it.ray_y_sign   = SIGN_W'($urandom_range(0, 3));
                send_item(it, emitted, px);
                emitted_count++;

                top = SCREEN_H / 2 - hgt / 2;
                if (top < 0)
                    top = 0;
                bot = hgt / 2 + SCREEN_H / 2;
                if (bot >= SCREEN_H)
                    bot = SCREEN_H - 1;
                rows = (bot > top) ? bot - top : 0;
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    steps = rows + $urandom_range(0, 2);
                else if (sel < 8)
                    steps = (rows > 1) ? $urandom_range(1, rows - 1) : 1;
                else if (sel == 8)
                    steps = 0;
                else
                    steps = $urandom_range(1, 3);
                if (steps > 48)
                    steps = 48;
                repeat (steps)
                begin
                    send_item(random_step(), emitted, px);
                    if (emitted)
                    begin
                        pending_pixels.push_back(px);
                        emitted_count++;
                    end
                end
            end
            quiet = 1'b0;
            item_ch.valid <= 1'b0;
            drain_pixels();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
